// ===== rtl/core/bzs_pkg.sv =====
package bzs_pkg;

    // Fixed widths of the item fields.
    localparam int FIELD_BITS  = 24;
    localparam int IDX_BITS    = 2;
    localparam int SEG_BITS    = 6;

    // Curve parameter t is unsigned Q1.16, 0 to 65536.
    localparam int T_BITS      = 17;
    localparam int T_FRAC_BITS = 16;

    localparam int NUM_AXES    = 3;
    localparam int NUM_POINTS  = 4;
    localparam int NUM_LERPS   = NUM_POINTS - 1;

    // Last de Casteljau level (three levels: 0, 1, 2).
    localparam logic [1:0] LVL_LAST = 2'd2;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Restoring division of 65536 by n, one quotient bit per cycle.
    localparam int DIV_STEPS    = T_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);
    localparam logic [DIV_CNT_BITS-1:0] DIV_CNT_LAST = DIV_CNT_BITS'(DIV_STEPS - 1);

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_START = 1'b1
    } bzs_op_t;

    typedef struct packed {
        logic                         operation;
        logic [IDX_BITS-1:0]          point_index;
        logic signed [FIELD_BITS-1:0] coord_x;
        logic signed [FIELD_BITS-1:0] coord_y;
        logic signed [FIELD_BITS-1:0] coord_z;
        logic [SEG_BITS-1:0]          segments;
    } bzs_in_t;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] point_x;
        logic signed [FIELD_BITS-1:0] point_y;
        logic signed [FIELD_BITS-1:0] point_z;
        logic                         last_point;
    } bzs_out_t;

    // Classified command as it sits in the queue.
    typedef struct packed {
        logic                         is_start;
        logic [IDX_BITS-1:0]          idx;
        logic signed [FIELD_BITS-1:0] x;
        logic signed [FIELD_BITS-1:0] y;
        logic signed [FIELD_BITS-1:0] z;
        logic [SEG_BITS-1:0]          n;
    } bzs_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_CALC,
        ST_EMIT
    } bzs_state_t;

    typedef struct packed {
        logic mul_en;
        logic add_en;
    } bzs_lerp_ctl_t;

    typedef struct packed {
        logic busy;
        logic out_load;
    } bzs_back_stat_t;

endpackage

// ===== rtl/core/bzs_front.sv =====
module bzs_front #(
    parameter int MAX_SAMPLES = 64
) (
    input  bzs_pkg::bzs_in_t  item,
    output bzs_pkg::bzs_cmd_t cmd
);
    import bzs_pkg::*;

    localparam logic [SEG_BITS-1:0] N_MAX = SEG_BITS'(MAX_SAMPLES - 1);

    // Decode the operation, keep only the fields that matter for it and
    // clamp the segment count so a run never exceeds the sample limit.
    always_comb begin
        cmd.is_start = (item.operation == OP_START);
        cmd.idx      = item.point_index;
        cmd.x        = item.coord_x;
        cmd.y        = item.coord_y;
        cmd.z        = item.coord_z;
        cmd.n        = '0;
        if (cmd.is_start) begin
            cmd.idx = '0;
            cmd.x   = '0;
            cmd.y   = '0;
            cmd.z   = '0;
            cmd.n   = (item.segments > N_MAX) ? N_MAX : item.segments;
        end
    end

endmodule

// ===== rtl/core/bzs_cmd_fifo.sv =====
module bzs_cmd_fifo (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  bzs_pkg::bzs_cmd_t          push_cmd,
    input  logic                       pop,
    output bzs_pkg::bzs_cmd_t          head_cmd,
    output logic                       full,
    output logic                       empty,
    output logic [bzs_pkg::QCNT_BITS-1:0] count
);
    import bzs_pkg::*;

    bzs_cmd_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign full     = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign count    = count_reg;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/bzs_lerp.sv =====
module bzs_lerp #(
    parameter int COORD_BITS = 24
) (
    input  logic                          aclk,
    input  bzs_pkg::bzs_lerp_ctl_t        ctl,
    input  logic signed [COORD_BITS-1:0]  a,
    input  logic signed [COORD_BITS-1:0]  b,
    input  logic [bzs_pkg::T_BITS-1:0]    t,
    output logic signed [COORD_BITS-1:0]  res
);
    import bzs_pkg::*;

    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int PROD_BITS = DIFF_BITS + T_BITS + 1;
    localparam int SUM_BITS  = COORD_BITS + 2;
    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

    logic signed [DIFF_BITS-1:0]  diff;
    logic signed [T_BITS:0]       t_s;
    logic signed [PROD_BITS-1:0]  prod;
    logic signed [COORD_BITS-1:0] a_reg;
    logic signed [DIFF_BITS-1:0]  quot_reg;
    logic signed [SUM_BITS-1:0]   sum;
    logic signed [63:0]           sat_w;
    logic signed [COORD_BITS-1:0] res_reg;

    // Multiply step, registered: (b - a) * t, with the floor shift by 2^16 taken as wiring.
    assign diff = DIFF_BITS'(b) - DIFF_BITS'(a);
    assign t_s  = $signed({1'b0, t});
    assign prod = PROD_BITS'(diff) * PROD_BITS'(t_s);

    // Add step, registered: add back a and saturate.
    assign sum = SUM_BITS'(a_reg) + SUM_BITS'(quot_reg);

    always_comb begin
        sat_w = 64'(sum);
        if (sat_w > SAT_HI) begin
            sat_w = SAT_HI;
        end else if (sat_w < SAT_LO) begin
            sat_w = SAT_LO;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            a_reg    <= a;
            quot_reg <= $signed(prod[COORD_BITS+T_FRAC_BITS:T_FRAC_BITS]);
        end
        if (ctl.add_en) begin
            res_reg <= COORD_BITS'(sat_w);
        end
    end

    assign res = res_reg;

endmodule

// ===== rtl/core/bzs_back.sv =====
module bzs_back #(
    parameter int COORD_BITS = 24
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cmd_valid,
    input  bzs_pkg::bzs_cmd_t       cmd,
    output logic                    cmd_pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output bzs_pkg::bzs_out_t       m_data,
    output bzs_pkg::bzs_back_stat_t stat
);
    import bzs_pkg::*;

    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

    function automatic logic signed [COORD_BITS-1:0] sat_field(
        input logic signed [FIELD_BITS-1:0] v
    );
        logic signed [63:0] w;
        w = 64'(v);
        if (w > SAT_HI) begin
            w = SAT_HI;
        end else if (w < SAT_LO) begin
            w = SAT_LO;
        end
        return COORD_BITS'(w);
    endfunction

    bzs_state_t state_reg;
    bzs_state_t state_next;

    logic signed [COORD_BITS-1:0] ctrl_reg [NUM_AXES][NUM_POINTS];
    logic signed [COORD_BITS-1:0] res      [NUM_AXES][NUM_LERPS];

    logic [SEG_BITS-1:0]     n_reg;
    logic [SEG_BITS-1:0]     i_reg;
    logic [T_BITS-1:0]       t_reg;
    logic [SEG_BITS-1:0]     rem_reg;
    logic [T_BITS-1:0]       step_q_reg;
    logic [SEG_BITS-1:0]     step_r_reg;
    logic [DIV_CNT_BITS-1:0] div_cnt_reg;
    logic [1:0]              lvl_reg;
    logic                    ph_reg;
    logic                    out_valid_reg;
    bzs_out_t                out_data_reg;

    bzs_lerp_ctl_t lerp_ctl;
    logic          out_load;
    logic          run_done;

    logic [SEG_BITS:0]   div_trial;
    logic                div_ge;
    logic [SEG_BITS:0]   div_sub;
    logic [SEG_BITS-1:0] div_rem;
    logic [SEG_BITS:0]   rem_sum;
    logic                rem_wrap;
    logic [SEG_BITS:0]   rem_sub;
    logic [SEG_BITS-1:0] rem_new;
    logic [T_BITS-1:0]   t_new;

    assign run_done = (i_reg == n_reg);

    // Output decode.
    always_comb begin
        cmd_pop         = (state_reg == ST_IDLE) && cmd_valid;
        lerp_ctl.mul_en = (state_reg == ST_CALC) && !ph_reg;
        lerp_ctl.add_en = (state_reg == ST_CALC) && ph_reg;
        out_load        = (state_reg == ST_EMIT) && (!out_valid_reg || m_ready);
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && cmd.is_start) begin
                    state_next = (cmd.n == '0) ? ST_CALC : ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_cnt_reg == DIV_CNT_LAST) begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                if (ph_reg && (lvl_reg == LVL_LAST)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    state_next = run_done ? ST_IDLE : ST_CALC;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // One restoring division step; the dividend 65536 has only its top bit set.
    assign div_trial = {step_r_reg, (div_cnt_reg == '0)};
    assign div_ge    = (div_trial >= {1'b0, n_reg});
    assign div_sub   = div_trial - {1'b0, n_reg};
    assign div_rem   = div_ge ? div_sub[SEG_BITS-1:0] : div_trial[SEG_BITS-1:0];

    // t advances by the quotient plus a carry from the running remainder.
    assign rem_sum  = {1'b0, rem_reg} + {1'b0, step_r_reg};
    assign rem_wrap = (rem_sum >= {1'b0, n_reg});
    assign rem_sub  = rem_sum - {1'b0, n_reg};
    assign rem_new  = rem_wrap ? rem_sub[SEG_BITS-1:0] : rem_sum[SEG_BITS-1:0];
    assign t_new    = t_reg + step_q_reg + T_BITS'(rem_wrap);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int ax = 0; ax < NUM_AXES; ax++) begin
                for (int p = 0; p < NUM_POINTS; p++) begin
                    ctrl_reg[ax][p] <= '0;
                end
            end
        end else begin
            state_reg <= state_next;
            if (cmd_pop && !cmd.is_start) begin
                ctrl_reg[0][cmd.idx] <= sat_field(cmd.x);
                ctrl_reg[1][cmd.idx] <= sat_field(cmd.y);
                ctrl_reg[2][cmd.idx] <= sat_field(cmd.z);
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_pop && cmd.is_start) begin
            n_reg       <= cmd.n;
            i_reg       <= '0;
            t_reg       <= '0;
            rem_reg     <= '0;
            step_q_reg  <= '0;
            step_r_reg  <= '0;
            div_cnt_reg <= '0;
            lvl_reg     <= '0;
            ph_reg      <= 1'b0;
        end
        if (state_reg == ST_DIV) begin
            step_r_reg  <= div_rem;
            step_q_reg  <= {step_q_reg[T_BITS-2:0], div_ge};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        if (state_reg == ST_CALC) begin
            ph_reg <= !ph_reg;
            if (ph_reg) begin
                lvl_reg <= (lvl_reg == LVL_LAST) ? 2'd0 : lvl_reg + 2'd1;
            end
        end
        if (out_load) begin
            out_data_reg.point_x    <= FIELD_BITS'(res[0][0]);
            out_data_reg.point_y    <= FIELD_BITS'(res[1][0]);
            out_data_reg.point_z    <= FIELD_BITS'(res[2][0]);
            out_data_reg.last_point <= run_done;
            if (!run_done) begin
                i_reg   <= i_reg + 1'b1;
                t_reg   <= t_new;
                rem_reg <= rem_new;
            end
        end
    end

    // Three lerp units per axis. Level 0 reads the control points; the later
    // levels read neighboring results of the level before.
    for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_axis
        for (genvar k = 0; k < NUM_LERPS; k++) begin : g_lerp
            logic signed [COORD_BITS-1:0] a_in;
            logic signed [COORD_BITS-1:0] b_in;
            logic signed [COORD_BITS-1:0] b_next;

            if (k + 1 < NUM_LERPS) begin : g_pair
                assign b_next = res[ax][k+1];
            end else begin : g_tail
                assign b_next = res[ax][k];
            end

            assign a_in = (lvl_reg == 2'd0) ? ctrl_reg[ax][k]   : res[ax][k];
            assign b_in = (lvl_reg == 2'd0) ? ctrl_reg[ax][k+1] : b_next;

            bzs_lerp #(
                .COORD_BITS (COORD_BITS)
            ) u_lerp (
                .aclk (aclk),
                .ctl  (lerp_ctl),
                .a    (a_in),
                .b    (b_in),
                .t    (t_reg),
                .res  (res[ax][k])
            );
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;
    assign stat    = '{busy: (state_reg != ST_IDLE), out_load: out_load};

endmodule

// ===== rtl/core/cubic_bezier_sampler.sv =====
// Cubic Bezier sampler. Each beat on the s_ side is a command: a load
// (operation 0) stores control point point_index, its coordinates saturated to
// COORD_BITS, and produces nothing; a start (operation 1) with n segments
// produces n+1 beats on the m_ side, the curve at t = floor(i*65536/n) for
// i = 0 to n, by de Casteljau evaluation with every lerp floored and
// saturated, the final beat flagged by last_point. n = 0 gives one point at
// control point 0, and n is clamped to MAX_SAMPLES-1. Commands go through a
// four-entry queue, so the input keeps taking beats while a run is under
// way until the queue is full. The back end handles one command at a time.
// A start is issued, then a bit-serial division of 65536 by n gives the
// step of t (skipped for n = 0); each point then takes three lerp levels,
// each a multiply and then an add and saturate, on nine lerp units, and is
// loaded into the output register. The next point is computed while the
// previous one waits in the output register. Control points reset to zero
// at once; there is no clearing pass.
module cubic_bezier_sampler #(
    parameter int MAX_SAMPLES = 64,
    parameter int COORD_BITS  = 24
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bzs_pkg::bzs_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output bzs_pkg::bzs_out_t m_data
);
    import bzs_pkg::*;

    bzs_cmd_t             front_cmd;
    bzs_cmd_t             head_cmd;
    logic                 fifo_full;
    logic                 fifo_empty;
    logic [QCNT_BITS-1:0] fifo_count;
    logic                 cmd_pop;
    bzs_back_stat_t       back_stat;

    // Front end: decode and clamp each incoming beat.
    bzs_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .item (s_data),
        .cmd  (front_cmd)
    );

    // The queue decouples the input from the evaluation engine.
    bzs_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (s_valid),
        .push_cmd (front_cmd),
        .pop      (cmd_pop),
        .head_cmd (head_cmd),
        .full     (fifo_full),
        .empty    (fifo_empty),
        .count    (fifo_count)
    );

    assign s_ready = !fifo_full;

    // Back end: control point store, t stepping and the lerp datapath.
    bzs_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (!fifo_empty),
        .cmd       (head_cmd),
        .cmd_pop   (cmd_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .stat      (back_stat)
    );

    // The queue never holds more entries than it has.
    a_fifo_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_count <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("command queue count exceeds its depth");

    // An accepted beat with no pop in the same cycle grows the queue by one.
    a_fifo_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !cmd_pop) |=>
            (fifo_count == QCNT_BITS'($past(fifo_count) + 1'b1)))
        else $error("accepted beat did not enter the command queue");

    // The back end takes no new command while a run is in progress.
    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        back_stat.busy |-> !cmd_pop)
        else $error("command popped during a run");

    // A point is written to the output register only when it is free.
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        back_stat.out_load |-> (!m_valid || m_ready))
        else $error("output register overwritten while still held");

endmodule
